// ----- rtl/mse_pkg.sv -----
// shared types and constants for the merge sort engine
`default_nettype none

package mse_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // input beat payload
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_in_item;

    // output beat payload
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        S_LOAD,
        S_SETUP,
        S_MERGE,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rewind;
        logic init;
        logic step;
        logic out_adv;
        logic clear;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sort_more;
        logic pass_end;
        logic out_last;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/merge_sort_engine_unit.sv -----
// top level of the merge sort engine: controller plus datapath
`default_nettype none

// Collects signed 32-bit values, one per input beat, into a buffer of
// MAX_ELEMENTS entries; beats that arrive with the buffer full are dropped.
// The beat with last_item set closes the set (it is stored first if there is
// room), and the n loaded values are sorted ascending by a stable bottom-up
// merge sort (ties keep input order), then sent out as n output beats with
// last_result set on the final one. Input is stalled from the closing beat
// until the final output beat is taken. Loading never stalls an offered beat
// before the closing one; the sort then runs ceil(log2 n) passes, each a
// setup state that restarts the pointers followed by one merge step per cycle
// through a single comparator and one write into the other buffer; output
// then fetches the first value in the final setup state and hands out the
// next value each time the sink takes a beat.
// Both buffers start undefined and need no clearing after reset.

module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input beats
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    // output beats
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: load, pass setup, merge steps, output
    mse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_in_item.last_item),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // two ping-pong buffers, run pointers and the comparator
    mse_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/mse_ctrl.sv -----
// sequencer for load, merge passes and output of the merge sort engine
`default_nettype none

module mse_ctrl
    import mse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_last_item,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.rewind = 1'b1;
                if (i_stat.sort_more) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_MERGE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MERGE: begin
                o_cmd.step = 1'b1;
                if (i_stat.pass_end) begin
                    n_state = S_SETUP;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_adv = 1'b1;
                    if (i_stat.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a set always ends with a flagged beat before loading resumes
    a_out_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_LOAD) |-> i_stat.out_last)
        else $error("left output before last beat");

    // merging only follows a pass setup that found more passes
    a_merge_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE && $past(r_state) != S_MERGE) |-> $past(i_stat.sort_more))
        else $error("merge entered without pending pass");

    // inputs are never taken while results are pending
    a_no_load_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during output");
`endif

endmodule

`default_nettype wire

// ----- rtl/mse_dpath.sv -----
// ping-pong buffers, merge pointers and comparator of the merge sort engine
`default_nettype none

module mse_dpath
    import mse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_in_item i_in_item,
    output t_stat         o_stat,
    output t_out_item     o_out_item
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    // buffer a holds the loaded set, buffers alternate as merge source
    logic [DATA_W-1:0] r_mem_a [MAX_ELEMENTS];
    logic [DATA_W-1:0] r_mem_b [MAX_ELEMENTS];
    logic [DATA_W-1:0] r_a_left, r_a_right, r_b_left, r_b_right;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW:0]   r_width, n_width;
    logic          r_src, n_src;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_mid, n_mid, r_hi, n_hi;

    logic signed [DATA_W-1:0] head_l, head_r;
    logic          left_ok, right_ok, take_left, run_end, load_ok;
    logic [CW-1:0] i1, j1, init_mid, init_hi, run_mid, run_hi;
    logic          we_a, we_b;
    logic [AW-1:0] w_addr;
    logic [DATA_W-1:0] w_data;

    function automatic logic [CW-1:0] f_clamp(input logic [CW+1:0] v, input logic [CW-1:0] n);
        f_clamp = (v < {2'b00, n}) ? v[CW-1:0] : n;
    endfunction

    assign head_l = r_src ? r_b_left  : r_a_left;
    assign head_r = r_src ? r_b_right : r_a_right;

    assign left_ok   = r_i < r_mid;
    assign right_ok  = r_j < r_hi;
    // ties go to the left run
    assign take_left = left_ok && (!right_ok || (head_l <= head_r));
    assign i1        = r_i + {{(CW-1){1'b0}}, take_left};
    assign j1        = r_j + {{(CW-1){1'b0}}, !take_left};
    assign run_end   = (i1 == r_mid) && (j1 == r_hi);

    assign init_mid = f_clamp({1'b0, r_width}, r_cnt);
    assign init_hi  = f_clamp({r_width, 1'b0}, r_cnt);
    assign run_mid  = f_clamp({2'b00, r_hi} + {1'b0, r_width}, r_cnt);
    assign run_hi   = f_clamp({2'b00, r_hi} + {r_width, 1'b0}, r_cnt);

    assign load_ok = i_cmd.load && (r_cnt < CW'(MAX_ELEMENTS));

    assign o_stat.sort_more = r_width < {1'b0, r_cnt};
    assign o_stat.pass_end  = (r_k + CW'(1)) == r_cnt;
    assign o_stat.out_last  = (r_i + CW'(1)) == r_cnt;

    assign o_out_item.sorted_value = head_l;
    assign o_out_item.last_result  = o_stat.out_last;

    always_comb begin
        n_cnt   = r_cnt;
        n_width = r_width;
        n_src   = r_src;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        we_a    = 1'b0;
        we_b    = 1'b0;
        w_addr  = r_k[AW-1:0];
        w_data  = take_left ? head_l : head_r;
        if (load_ok) begin
            we_a   = 1'b1;
            w_addr = r_cnt[AW-1:0];
            w_data = i_in_item.value;
            n_cnt  = r_cnt + CW'(1);
        end
        if (i_cmd.rewind) begin
            n_i = '0;
        end
        if (i_cmd.init) begin
            n_k   = '0;
            n_mid = init_mid;
            n_j   = init_mid;
            n_hi  = init_hi;
        end
        if (i_cmd.step) begin
            we_a = r_src;
            we_b = !r_src;
            n_k  = r_k + CW'(1);
            if (o_stat.pass_end) begin
                n_src   = !r_src;
                n_width = {r_width[CW-1:0], 1'b0};
            end else if (run_end) begin
                n_i   = r_hi;
                n_mid = run_mid;
                n_j   = run_mid;
                n_hi  = run_hi;
            end else begin
                n_i = i1;
                n_j = j1;
            end
        end
        if (i_cmd.out_adv) begin
            n_i = r_i + CW'(1);
        end
        if (i_cmd.clear) begin
            n_cnt   = '0;
            n_width = (CW+1)'(1);
            n_src   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_width <= (CW+1)'(1);
            r_src   <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_width <= n_width;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
    end

    // reads follow the next pointer values so heads are ready each cycle
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[w_addr] <= w_data;
        end
        r_a_left  <= r_mem_a[n_i[AW-1:0]];
        r_a_right <= r_mem_a[n_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[w_addr] <= w_data;
        end
        r_b_left  <= r_mem_b[n_i[AW-1:0]];
        r_b_right <= r_mem_b[n_j[AW-1:0]];
    end

`ifndef SYNTHESIS
    a_step_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (left_ok || right_ok))
        else $error("merge step with both runs empty");

    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_i <= r_mid && r_mid <= r_j && r_j <= r_hi && r_hi <= r_cnt))
        else $error("merge pointers out of order");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_k < r_cnt))
        else $error("merge write beyond set");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_adv |-> (r_i < r_cnt))
        else $error("output index beyond set");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ELEMENTS))
        else $error("loaded count above capacity");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/merge_sort_engine_unit_tb.sv -----
// testbench for the merge sort engine: random and directed sets checked beat by beat
module merge_sort_engine_unit_tb;
    import mse_pkg::*;

    localparam int SET_CAP    = MAX_ELEMENTS_DEF;
    localparam int HALF_CLK   = 10;
    localparam int SHOW_LIMIT = 10;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // every signal the block sees is known from time zero
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // idling knobs, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off: requested by a test, counted down by the stall process
    int hold_req       = 0;
    int hold_left      = 0;

    int mismatch_count = 0;

    // values of the set being loaded, as the block should hold them
    logic signed [DATA_W-1:0] pending_set[$];
    // sorted beats still owed by the block, oldest first
    t_out_item sorted_expect_q[$];

    merge_sort_engine_unit #(
        .MAX_ELEMENTS(SET_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always #HALF_CLK i_clk = ~i_clk;

    // record one failure, printing only the first few in detail
    task automatic flag_mismatch(input string what, input logic [DATA_W:0] exp_bits,
                                 input logic [DATA_W:0] act_bits);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT) begin
            $display("mismatch %0d: %s expected %h got %h at %0t",
                     mismatch_count, what, exp_bits, act_bits, $realtime);
        end
    endtask

    // take one accepted beat into the prediction: store while there is room,
    // and on the closing beat sort the loaded values and queue them as results
    task automatic predict_sorted(input logic signed [DATA_W-1:0] v, input logic lst);
        logic signed [DATA_W-1:0] key;
        t_out_item                beat;
        int                       j;
        if (pending_set.size() < SET_CAP) begin
            pending_set.push_back(v);
        end
        if (lst) begin
            // stable insertion sort: equal values keep their load order
            for (int k = 1; k < pending_set.size(); k++) begin
                key = pending_set[k];
                j = k - 1;
                while (j >= 0 && pending_set[j] > key) begin
                    pending_set[j+1] = pending_set[j];
                    j--;
                end
                pending_set[j+1] = key;
            end
            for (int k = 0; k < pending_set.size(); k++) begin
                beat.sorted_value = pending_set[k];
                beat.last_result  = (k == pending_set.size() - 1);
                sorted_expect_q.push_back(beat);
            end
            pending_set.delete();
        end
    endtask

    // receiver side: random stall, or a counted hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker: every output beat taken is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_beat;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (sorted_expect_q.size() == 0) begin
                flag_mismatch("unexpected beat", '0, o_out_item);
            end else begin
                exp_beat = sorted_expect_q.pop_front();
                if (o_out_item.sorted_value !== exp_beat.sorted_value) begin
                    flag_mismatch("sorted_value", (DATA_W+1)'(exp_beat.sorted_value),
                                  (DATA_W+1)'(o_out_item.sorted_value));
                end
                if (o_out_item.last_result !== exp_beat.last_result) begin
                    flag_mismatch("last_result", (DATA_W+1)'(exp_beat.last_result),
                                  (DATA_W+1)'(o_out_item.last_result));
                end
            end
        end
    end

    // offer one beat, with a random idle gap first, and hold it until taken;
    // valid stays high on return so back-to-back beats need no second assignment
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst);
        t_in_item item;
        item.value     = v;
        item.last_item = lst;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_sorted(v, lst);
    endtask

    // stop offering and wait until every owed beat has come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // random element: full range, a narrow band to force ties, or an extreme
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(3))
            0, 1:    v = $urandom;
            2:       v = $urandom_range(16) - 8;
            default: begin
                case ($urandom_range(4))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    // mostly short sets, some mid-size, a few large ones that can reach or overrun the buffer
    function automatic int pick_set_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) return $urandom_range(12, 1);
        if (sel < 95) return $urandom_range(40, 13);
        return $urandom_range(SET_CAP + 8, 41);
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++) begin
            send_item(pick_value(), k == n - 1);
        end
    endtask

    // extremes, ties, single and two element sets, already and reverse ordered sets
    task automatic test_directed();
        logic signed [DATA_W-1:0] ties[10];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ties = '{5, -3, 5, -3, 0, VAL_MAX, VAL_MIN, -1, 1, 5};
        send_item(0, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);
        for (int k = 0; k < 10; k++) send_item(ties[k], k == 9);
        for (int k = 0; k < 4; k++) send_item(k - 2, k == 3);
        for (int k = 0; k < 4; k++) send_item(2 - k, k == 3);
        wait_drain();
    endtask

    // a set that exactly fills the buffer, then sets whose extra beats are dropped,
    // the closing beat itself among them
    task automatic test_buffer_full();
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        send_set(SET_CAP);
        send_set(SET_CAP + 6);
        send_set(SET_CAP + 1);
        wait_drain();
    endtask

    // random sets under one idling setting until the beat budget is spent
    task automatic test_random(input int idle_pct, input int stall_pct, input int budget);
        int sent;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget) begin
            n = pick_set_size();
            send_set(n);
            sent += n;
        end
        wait_drain();
    endtask

    // receiver holds off long enough that the sorted set backs up and the
    // block stalls its input while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 600;
        for (int s = 0; s < 3; s++) send_set(20);
        wait_drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_buffer_full();
        test_random(0, 0, 40);
        test_random(78, 0, 40);
        test_random(0, 78, 40);
        test_random(34, 34, 40);
        test_backpressure();

        // let any stray beat show up before judging
        recv_stall_pct = 0;
        repeat (40) @(posedge i_clk);
        if (sorted_expect_q.size() != 0) begin
            flag_mismatch("missing beats", (DATA_W+1)'(sorted_expect_q.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("merge_sort_engine_unit_tb: clean");
        end else begin
            $display("merge_sort_engine_unit_tb: errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #8_000_000;
        $display("merge_sort_engine_unit_tb: errors");
        $finish;
    end

endmodule
